@@ design/nps_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, command/status structs and fixed-point helpers
// for the nearest-point screen pick block. No dependencies.
package nps_pkg;

   localparam int POINT_W    = 20;
   localparam int COORD_W    = 21;
   localparam int E_W        = 22;
   localparam int AXIS_W     = 20;
   localparam int PROD_W     = 42;
   localparam int ACC_W      = 44;
   localparam int Q_W        = 32;
   localparam int DIV_NUM_W  = 48;
   localparam int DIV_DEN_W  = 31;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_EYE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSP  = 3'd7;

   // axis selection for the shared dot-product unit
   localparam logic [1:0] AXIS_VIEW  = 2'd0;
   localparam logic [1:0] AXIS_RIGHT = 2'd1;
   localparam logic [1:0] AXIS_UP    = 2'd2;

   // operand selection for the shared squaring multiplier
   localparam logic [1:0] SQ_DX = 2'd0;
   localparam logic [1:0] SQ_DY = 2'd1;
   localparam logic [1:0] SQ_R  = 2'd2;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic       load;
      logic       mac_clr;
      logic       mac_mul;
      logic       mac_add;
      logic [1:0] mac_k;
      logic [1:0] axis_sel;
      logic       depth_st;
      logic       proj_st;
      logic       proj_div;
      logic       proj_sel;
      logic       div_start;
      logic       rad_st;
      logic       sq_mul;
      logic [1:0] sq_sel;
      logic       sum_clr;
      logic       sum_add;
      logic       commit;
      logic       take;
      logic       emit;
   } nps_cmd_type;

   typedef struct packed {
      logic near_ok;
      logic persp;
      logic div_done;
      logic radius_ok;
      logic last;
   } nps_status_type;

   function automatic logic signed [Q_W-1:0] sat_q16(input logic signed [48:0] v);
      if (v > 49'sd2147483647)
         sat_q16 = Q_MAX;
      else if (v < -49'sd2147483648)
         sat_q16 = Q_MIN;
      else
         sat_q16 = v[Q_W-1:0];
   endfunction

   // Q.28 to Q15.16, round half up, saturate
   function automatic logic signed [Q_W-1:0] round_q16(input logic signed [45:0] v);
      logic signed [45:0] t;
      t = (v + 46'sd2048) >>> 12;
      round_q16 = sat_q16({{3{t[45]}}, t});
   endfunction

endpackage

@@ design/nps_divider.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nps_pkg.
module nps_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [nps_pkg::DIV_NUM_W-1:0]  num,
   input  logic [nps_pkg::DIV_DEN_W-1:0]  den,
   output logic                           done,
   output logic [nps_pkg::DIV_NUM_W-1:0]  quot
);
   import nps_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]     rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]   quo_ff, quo_in;
   logic [DIV_DEN_W-1:0]   den_ff, den_in;
   logic [DIV_DEN_W+1:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {2'b00, den_ff}) begin
            rem_in = (DIV_DEN_W+1)'(trial - {2'b00, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

@@ design/nps_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, dot-product MAC, projection,
// radius test, best-point tracking and result register. Uses nps_pkg, nps_divider.
module nps_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [nps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nps_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_z,
   input  logic                                  req_last_point,
   input  nps_pkg::nps_cmd_type                  cmd,
   output nps_pkg::nps_status_type               status,
   output logic                                  rsp_found,
   output logic [nps_pkg::POINT_W-1:0]           rsp_nearest_index,
   output logic signed [nps_pkg::Q_W-1:0]        rsp_nearest_depth
);
   import nps_pkg::*;

   logic [62:0]              eye_ff;
   logic [59:0]              right_ff, up_ff, view_ff;
   logic signed [Q_W-1:0]    near_ff;
   logic [63:0]              click_ff;
   logic [30:0]              radius_ff;
   logic                     persp_ff;

   logic signed [E_W-1:0]    e_ff [3];
   logic                     last_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [Q_W-1:0]    depth_ff;
   logic signed [Q_W-1:0]    proj_ff [2];
   logic                     neg_ff;
   logic [32:0]              dxa_ff, dya_ff, dxa_in, dya_in;
   logic                     gt_ff;
   logic [61:0]              sq_ff;
   logic [62:0]              sum_ff, sum_in;

   logic signed [Q_W-1:0]    best_depth_ff;
   logic [POINT_W-1:0]       best_index_ff, count_ff;
   logic                     any_ff;
   logic                     found_ff;
   logic [POINT_W-1:0]       index_ff;
   logic signed [Q_W-1:0]    rdepth_ff;

   logic [59:0]              axis_vec;
   logic signed [E_W-1:0]    e_sel;
   logic signed [AXIS_W-1:0] ax_sel;
   logic signed [45:0]       acc_ext;
   logic [ACC_W-1:0]         acc_abs;
   logic                     div_done;
   logic [DIV_NUM_W-1:0]     div_quot;
   logic signed [48:0]       div_signed;
   logic signed [Q_W-1:0]    proj_new;
   logic signed [32:0]       dx, dy;
   logic [30:0]              sq_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff    <= '0;
         right_ff  <= '0;
         up_ff     <= '0;
         view_ff   <= '0;
         near_ff   <= '0;
         click_ff  <= '0;
         radius_ff <= '0;
         persp_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EYE:    eye_ff    <= csr_wdata[62:0];
            CSR_RIGHT:  right_ff  <= csr_wdata[59:0];
            CSR_UP:     up_ff     <= csr_wdata[59:0];
            CSR_VIEW:   view_ff   <= csr_wdata[59:0];
            CSR_NEAR:   near_ff   <= csr_wdata[31:0];
            CSR_CLICK:  click_ff  <= csr_wdata;
            CSR_RADIUS: radius_ff <= csr_wdata[30:0];
            CSR_PERSP:  persp_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // operand selection for the MAC
   always_comb begin
      unique case (cmd.axis_sel)
         AXIS_RIGHT: axis_vec = right_ff;
         AXIS_UP:    axis_vec = up_ff;
         default:    axis_vec = view_ff;
      endcase
      case (cmd.mac_k)
         2'd1: begin
            e_sel  = e_ff[1];
            ax_sel = axis_vec[39:20];
         end
         2'd2: begin
            e_sel  = e_ff[2];
            ax_sel = axis_vec[59:40];
         end
         default: begin
            e_sel  = e_ff[0];
            ax_sel = axis_vec[19:0];
         end
      endcase
   end

   assign prod_in = e_sel * ax_sel;

   always_comb begin
      if (cmd.mac_clr)
         acc_in = '0;
      else if (cmd.mac_add)
         acc_in = acc_ff + {{2{prod_ff[PROD_W-1]}}, prod_ff};
      else
         acc_in = acc_ff;
   end

   assign acc_ext = {{2{acc_ff[ACC_W-1]}}, acc_ff};
   assign acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;

   nps_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({acc_abs, 4'b0000}),
      .den   (depth_ff[DIV_DEN_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_signed = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign proj_new   = cmd.proj_div ? sat_q16(div_signed) : round_q16(acc_ext);

   // distances to the click point, magnitudes only
   assign dx     = {proj_ff[0][Q_W-1], proj_ff[0]} - {click_ff[31], click_ff[31:0]};
   assign dy     = {proj_ff[1][Q_W-1], proj_ff[1]} - {click_ff[63], click_ff[63:32]};
   assign dxa_in = dx[32] ? 33'(-dx) : dx;
   assign dya_in = dy[32] ? 33'(-dy) : dy;

   always_comb begin
      case (cmd.sq_sel)
         SQ_DX:   sq_op = dxa_ff[30:0];
         SQ_DY:   sq_op = dya_ff[30:0];
         default: sq_op = radius_ff;
      endcase
      if (cmd.sum_clr)
         sum_in = '0;
      else if (cmd.sum_add)
         sum_in = sum_ff + {1'b0, sq_ff};
      else
         sum_in = sum_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff[0] <= {req_point_x[COORD_W-1], req_point_x} - {eye_ff[20], eye_ff[20:0]};
         e_ff[1] <= {req_point_y[COORD_W-1], req_point_y} - {eye_ff[41], eye_ff[41:21]};
         e_ff[2] <= {req_point_z[COORD_W-1], req_point_z} - {eye_ff[62], eye_ff[62:42]};
         last_ff <= req_last_point;
      end
      if (cmd.mac_mul)
         prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (cmd.depth_st)
         depth_ff <= round_q16(-acc_ext);
      if (cmd.div_start)
         neg_ff <= acc_ff[ACC_W-1];
      if (cmd.proj_st)
         proj_ff[cmd.proj_sel] <= proj_new;
      if (cmd.rad_st) begin
         dxa_ff <= dxa_in;
         dya_ff <= dya_in;
         gt_ff  <= (dxa_in > {2'b00, radius_ff}) || (dya_in > {2'b00, radius_ff});
      end
      if (cmd.sq_mul)
         sq_ff <= sq_op * sq_op;
      sum_ff <= sum_in;
      if (cmd.emit) begin
         found_ff  <= any_ff;
         index_ff  <= any_ff ? best_index_ff : '0;
         rdepth_ff <= any_ff ? best_depth_ff : '0;
      end
   end

   // running best; emit clears it for the next set
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         best_depth_ff <= Q_MAX;
         best_index_ff <= '0;
         any_ff        <= 1'b0;
         count_ff      <= '0;
      end else if (cmd.commit) begin
         if (cmd.take && (!any_ff || depth_ff < best_depth_ff)) begin
            best_depth_ff <= depth_ff;
            best_index_ff <= count_ff;
            any_ff        <= 1'b1;
         end
         count_ff <= count_ff + 1'b1;
      end
   end

   assign status.near_ok   = (depth_ff >= near_ff) && !(persp_ff && depth_ff <= 0);
   assign status.persp     = persp_ff;
   assign status.div_done  = div_done;
   assign status.radius_ok = !gt_ff && !(sum_ff > {1'b0, sq_ff});
   assign status.last      = last_ff;

   assign rsp_found         = found_ff;
   assign rsp_nearest_index = index_ff;
   assign rsp_nearest_depth = rdepth_ff;

endmodule

@@ design/nps_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences one point through the datapath and owns both handshakes.
// Uses nps_pkg.
module nps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  nps_pkg::nps_status_type  status,
   output nps_pkg::nps_cmd_type     cmd
);
   import nps_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DOTV   = 4'd1;
   localparam logic [3:0] ST_DEPTH  = 4'd2;
   localparam logic [3:0] ST_NEAR   = 4'd3;
   localparam logic [3:0] ST_DOTR   = 4'd4;
   localparam logic [3:0] ST_PROJR  = 4'd5;
   localparam logic [3:0] ST_DIVR   = 4'd6;
   localparam logic [3:0] ST_DOTU   = 4'd7;
   localparam logic [3:0] ST_PROJU  = 4'd8;
   localparam logic [3:0] ST_DIVU   = 4'd9;
   localparam logic [3:0] ST_RAD    = 4'd10;
   localparam logic [3:0] ST_SQ     = 4'd11;
   localparam logic [3:0] ST_COMMIT = 4'd12;
   localparam logic [3:0] ST_SKIP   = 4'd13;
   localparam logic [3:0] ST_EMIT   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DOTV;
            end
         end
         ST_DOTV, ST_DOTR, ST_DOTU: begin
            cmd.mac_clr  = (cnt_ff == 2'd0);
            cmd.mac_mul  = (cnt_ff != 2'd3);
            cmd.mac_add  = (cnt_ff != 2'd0);
            cmd.mac_k    = cnt_ff;
            cmd.axis_sel = (state_ff == ST_DOTR) ? AXIS_RIGHT :
                           (state_ff == ST_DOTU) ? AXIS_UP : AXIS_VIEW;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               if (state_ff == ST_DOTV)
                  state_in = ST_DEPTH;
               else if (state_ff == ST_DOTR)
                  state_in = ST_PROJR;
               else
                  state_in = ST_PROJU;
            end
         end
         ST_DEPTH: begin
            cmd.depth_st = 1'b1;
            state_in     = ST_NEAR;
         end
         ST_NEAR: begin
            cnt_in   = '0;
            state_in = status.near_ok ? ST_DOTR : ST_SKIP;
         end
         ST_PROJR, ST_PROJU: begin
            cmd.proj_sel = (state_ff == ST_PROJU);
            cnt_in       = '0;
            if (status.persp) begin
               cmd.div_start = 1'b1;
               state_in      = (state_ff == ST_PROJU) ? ST_DIVU : ST_DIVR;
            end else begin
               cmd.proj_st = 1'b1;
               state_in    = (state_ff == ST_PROJU) ? ST_RAD : ST_DOTU;
            end
         end
         ST_DIVR, ST_DIVU: begin
            cmd.proj_sel = (state_ff == ST_DIVU);
            cnt_in       = '0;
            if (status.div_done) begin
               cmd.proj_st  = 1'b1;
               cmd.proj_div = 1'b1;
               state_in     = (state_ff == ST_DIVU) ? ST_RAD : ST_DOTU;
            end
         end
         ST_RAD: begin
            cmd.rad_st = 1'b1;
            cnt_in     = '0;
            state_in   = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_mul  = (cnt_ff != 2'd3);
            cmd.sq_sel  = (cnt_ff == 2'd0) ? SQ_DX : (cnt_ff == 2'd1) ? SQ_DY : SQ_R;
            cmd.sum_clr = (cnt_ff == 2'd0);
            cmd.sum_add = (cnt_ff == 2'd1) || (cnt_ff == 2'd2);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3)
               state_in = ST_COMMIT;
         end
         ST_COMMIT, ST_SKIP: begin
            cmd.commit = 1'b1;
            cmd.take   = (state_ff == ST_COMMIT) && status.radius_ok;
            state_in   = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVR || state_ff == ST_DIVU))
      else $error("divider finished outside a wait state");
   a_accept_starts_dot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DOTV))
      else $error("accepted request did not start the view dot product");
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_EMIT))
      else $error("result emitted over a pending response");
`endif

endmodule

@@ design/nearest_point_screen_pick.sv @@
`timescale 1ns / 1ps
// Nearest point screen pick: one request at a time, accepted only when idle.
// Points the near test drops skip the projections; orthographic points project directly,
// perspective points wait twice on the shared 48-bit divider, once per screen axis.
// After the last point of a set the controller enters an emit state; rsp_valid rises
// once it emits, later if an earlier result still waits. Reset (synchronous, active
// high) clears control, best-point state and configuration registers.
module nearest_point_screen_pick (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [nps_pkg::COORD_W-1:0]    req_point_z,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [nps_pkg::POINT_W-1:0]           rsp_nearest_index,
   output logic signed [nps_pkg::Q_W-1:0]        rsp_nearest_depth,
   input  logic                                  csr_wr_en,
   input  logic [nps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nps_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import nps_pkg::*;

   nps_cmd_type    cmd;
   nps_status_type status;

   // controller: sequence depth, near test, projections, radius test, update
   nps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: hold configuration, compute and track the nearest point
   nps_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .req_last_point    (req_last_point),
      .cmd               (cmd),
      .status            (status),
      .rsp_found         (rsp_found),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_nearest_depth (rsp_nearest_depth)
   );

endmodule
